@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HMT_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hmt assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define HMT_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hmt assertion failed");

`endif

@@ sv/hmt_pkg.sv @@
// ----------------------------------------------------------------------------
// hmt_pkg
// Types, codes and defaults shared by the membership table modules.
// ----------------------------------------------------------------------------
package hmt_pkg;

   localparam int TABLE_DEPTH_DEF  = 32;
   localparam int FAILED_DEPTH_DEF = 32;
   localparam int CSR_IDX_W        = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_FAIL_TIMEOUT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REMOVE_TIMEOUT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SELF_ID        = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SELF_PORT      = 2'd3;

   localparam logic [1:0] REQ_GOSSIP     = 2'd0;
   localparam logic [1:0] REQ_JOIN_REPLY = 2'd1;
   localparam logic [1:0] REQ_JOIN_REQ   = 2'd2;
   localparam logic [1:0] REQ_TICK       = 2'd3;

   localparam logic [2:0] ST_DONE     = 3'd0;
   localparam logic [2:0] ST_INSERTED = 3'd1;
   localparam logic [2:0] ST_FAILED   = 3'd2;
   localparam logic [2:0] ST_PRESENT  = 3'd3;
   localparam logic [2:0] ST_FULL     = 3'd4;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] member_id;
      logic [15:0] member_port;
      logic [31:0] member_heartbeat;
      logic [31:0] member_stamp;
      logic [31:0] current_time;
      logic        last_entry;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [5:0]  member_count;
      logic [5:0]  removed_count;
      logic [5:0]  newly_failed_count;
      logic [31:0] own_heartbeat;
      logic        in_group;
   } rsp_word_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] id;
      logic [15:0] port;
      logic [31:0] heartbeat;
      logic [31:0] stamp;
   } entry_type;

   typedef struct packed {
      logic       load;
      logic       wipe;
      logic       t_inc;
      logic       f_clr;
      logic       f_inc;
      logic       s_eval;
      logic       ins;
      logic       upd_gossip;
      logic       upd_self;
      logic       erase;
      logic       f_add;
      logic       st_we;
      logic [2:0] st_code;
      logic       grp_set;
   } cmd_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic       last_entry;
      logic       self_hit;
      logic       t_last;
      logic       t_d_last;
      logic       f_none;
      logic       f_end;
      logic       f_full;
      logic       f_hit;
      logic       found;
      logic       free_ok;
      logic       hb_newer;
      logic       e_valid;
      logic       e_self;
      logic       e_erase;
      logic       e_fail;
   } sts_type;

endpackage

@@ sv/heartbeat_membership_table.sv @@
// ----------------------------------------------------------------------------
// heartbeat_membership_table
// Gossip membership table with heartbeat based failure detection.
// ----------------------------------------------------------------------------
// An item (gossip entry, join reply entry, join request or tick) is taken at
// a clock edge where start is high and busy is low; busy stays high until
// its result word has been shown. The result word is on rsp_data, marked by
// rsp_strobe, which is high for exactly one cycle; the receiver cannot stall it.
// Control registers are written through csr_we, csr_index and csr_wdata, and
// writes take effect at once; the user is to write them only while the block
// is idle, which the block itself does not enforce. A join request or join
// reply entry gives its result word after a scan of the member memory, one
// entry a cycle, and busy falls in the cycle after the strobe. A join reply
// entry that names this node answers without that scan. A gossip entry first
// scans the failed store when it holds any address. A tick reads and checks
// each member entry in turn, and scans the failed store for each entry that
// has just aged past the fail limit. After reset the block runs a clearing
// pass over the member memory with busy high; control registers can be
// written meanwhile.
// ----------------------------------------------------------------------------
module heartbeat_membership_table #(
   parameter int TABLE_DEPTH  = hmt_pkg::TABLE_DEPTH_DEF,
   parameter int FAILED_DEPTH = hmt_pkg::FAILED_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  hmt_pkg::req_word_type         req_data,
   output logic                          rsp_strobe,
   output hmt_pkg::rsp_word_type         rsp_data,
   input  logic                          csr_we,
   input  logic [hmt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                   csr_wdata
);

   hmt_pkg::cmd_type cmd;
   hmt_pkg::sts_type sts;

   hmt_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .sts        (sts),
      .cmd        (cmd)
   );

   hmt_datapath #(
      .TABLE_DEPTH  (TABLE_DEPTH),
      .FAILED_DEPTH (FAILED_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_data)
   );

endmodule

@@ sv/hmt_datapath.sv @@
// ----------------------------------------------------------------------------
// hmt_datapath
// Member table and failed-address memories, scan indices, counters and
// control registers, driven by commands from the controller.
// ----------------------------------------------------------------------------
module hmt_datapath #(
   parameter int TABLE_DEPTH  = hmt_pkg::TABLE_DEPTH_DEF,
   parameter int FAILED_DEPTH = hmt_pkg::FAILED_DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [hmt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                  csr_wdata,
   input  hmt_pkg::req_word_type        req_data,
   input  hmt_pkg::cmd_type             cmd,
   output hmt_pkg::sts_type             sts,
   output hmt_pkg::rsp_word_type        rsp_data
);

   localparam int TIW = $clog2(TABLE_DEPTH);
   localparam int FIW = $clog2(FAILED_DEPTH);
   localparam int FCW = $clog2(FAILED_DEPTH + 1);

   hmt_pkg::entry_type    tbl_mem [TABLE_DEPTH];
   logic [47:0]           fail_mem [FAILED_DEPTH];

   hmt_pkg::req_word_type item_ff, item_in;
   hmt_pkg::entry_type    tbl_rd_ff;
   logic [47:0]           fail_rd_ff;
   logic [15:0]           fail_to_ff, fail_to_in, remove_to_ff, remove_to_in;
   logic [31:0]           self_id_ff, self_id_in;
   logic [15:0]           self_port_ff, self_port_in;
   logic [TIW-1:0]        t_idx_ff, t_idx_in, t_idx_d_ff;
   logic [FIW-1:0]        f_idx_ff, f_idx_in, f_idx_d_ff;
   logic                  found_ff, found_in, free_ff, free_in;
   logic [TIW-1:0]        found_idx_ff, found_idx_in, free_idx_ff, free_idx_in;
   logic [31:0]           found_hb_ff, found_hb_in;
   logic [FCW-1:0]        fail_cnt_ff, fail_cnt_in;
   logic [5:0]            member_cnt_ff, member_cnt_in;
   logic [5:0]            removed_ff, removed_in, newly_ff, newly_in;
   logic [31:0]           hb_ff, hb_in;
   logic                  group_ff, group_in;
   logic [2:0]            status_ff, status_in;

   logic                  tbl_we;
   logic [TIW-1:0]        tbl_waddr;
   hmt_pkg::entry_type    tbl_wdata;
   logic [47:0]           key;
   logic [31:0]           age;
   logic                  is_tick;
   logic                  rd_match;

   assign is_tick  = item_ff.req_type == hmt_pkg::REQ_TICK;
   assign key      = is_tick ? {tbl_rd_ff.id, tbl_rd_ff.port}
                             : {item_ff.member_id, item_ff.member_port};
   assign age      = item_ff.current_time - tbl_rd_ff.stamp;
   assign rd_match = tbl_rd_ff.valid && tbl_rd_ff.id == item_ff.member_id
                     && tbl_rd_ff.port == item_ff.member_port;

   always_comb begin
      fail_to_in   = fail_to_ff;
      remove_to_in = remove_to_ff;
      self_id_in   = self_id_ff;
      self_port_in = self_port_ff;
      if (csr_we) begin
         case (csr_index)
            hmt_pkg::CSR_FAIL_TIMEOUT:   fail_to_in   = csr_wdata[15:0];
            hmt_pkg::CSR_REMOVE_TIMEOUT: remove_to_in = csr_wdata[15:0];
            hmt_pkg::CSR_SELF_ID:        self_id_in   = csr_wdata;
            hmt_pkg::CSR_SELF_PORT:      self_port_in = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      item_in       = cmd.load ? req_data : item_ff;
      t_idx_in      = t_idx_ff;
      f_idx_in      = f_idx_ff;
      found_in      = found_ff;
      found_idx_in  = found_idx_ff;
      found_hb_in   = found_hb_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      fail_cnt_in   = fail_cnt_ff + FCW'(cmd.f_add);
      member_cnt_in = member_cnt_ff + 6'(cmd.ins) - 6'(cmd.erase);
      removed_in    = removed_ff + 6'(cmd.erase);
      newly_in      = newly_ff + 6'(cmd.f_add);
      hb_in         = hb_ff;
      group_in      = group_ff | cmd.grp_set;
      status_in     = cmd.st_we ? cmd.st_code : status_ff;
      if (cmd.load) begin
         t_idx_in   = '0;
         f_idx_in   = '0;
         found_in   = 1'b0;
         free_in    = 1'b0;
         removed_in = '0;
         newly_in   = '0;
         status_in  = hmt_pkg::ST_DONE;
         if (req_data.req_type == hmt_pkg::REQ_TICK) begin
            hb_in = hb_ff + 32'd1;
         end
      end else begin
         if (cmd.t_inc) begin
            t_idx_in = t_idx_ff + TIW'(1);
         end
         if (cmd.f_clr) begin
            f_idx_in = '0;
         end else if (cmd.f_inc) begin
            f_idx_in = f_idx_ff + FIW'(1);
         end
         if (cmd.s_eval && !found_ff && rd_match) begin
            found_in     = 1'b1;
            found_idx_in = t_idx_d_ff;
            found_hb_in  = tbl_rd_ff.heartbeat;
         end
         if (cmd.s_eval && !free_ff && !tbl_rd_ff.valid) begin
            free_in     = 1'b1;
            free_idx_in = t_idx_d_ff;
         end
      end
   end

   always_comb begin
      tbl_we    = cmd.wipe | cmd.ins | cmd.upd_gossip | cmd.upd_self | cmd.erase;
      tbl_waddr = t_idx_ff;
      tbl_wdata = tbl_rd_ff;
      if (cmd.wipe) begin
         tbl_wdata = '0;
      end else if (cmd.ins) begin
         tbl_waddr           = free_idx_ff;
         tbl_wdata.valid     = 1'b1;
         tbl_wdata.id        = item_ff.member_id;
         tbl_wdata.port      = item_ff.member_port;
         tbl_wdata.heartbeat = item_ff.member_heartbeat;
         tbl_wdata.stamp     = (item_ff.req_type == hmt_pkg::REQ_JOIN_REQ)
                               ? item_ff.current_time : item_ff.member_stamp;
      end else if (cmd.upd_gossip) begin
         tbl_waddr           = found_idx_ff;
         tbl_wdata.valid     = 1'b1;
         tbl_wdata.id        = item_ff.member_id;
         tbl_wdata.port      = item_ff.member_port;
         tbl_wdata.heartbeat = item_ff.member_heartbeat;
         tbl_wdata.stamp     = item_ff.current_time;
      end else if (cmd.upd_self) begin
         tbl_wdata.heartbeat = hb_ff;
         tbl_wdata.stamp     = item_ff.current_time;
      end else if (cmd.erase) begin
         tbl_wdata.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[tbl_waddr] <= tbl_wdata;
      end
      tbl_rd_ff <= tbl_mem[t_idx_ff];
      if (cmd.f_add) begin
         fail_mem[fail_cnt_ff[FIW-1:0]] <= key;
      end
      fail_rd_ff <= fail_mem[f_idx_ff];
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      t_idx_d_ff   <= t_idx_ff;
      f_idx_d_ff   <= f_idx_ff;
      found_idx_ff <= found_idx_in;
      found_hb_ff  <= found_hb_in;
      free_idx_ff  <= free_idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fail_to_ff    <= 16'd5;
         remove_to_ff  <= 16'd20;
         self_id_ff    <= '0;
         self_port_ff  <= '0;
         t_idx_ff      <= '0;
         f_idx_ff      <= '0;
         found_ff      <= 1'b0;
         free_ff       <= 1'b0;
         fail_cnt_ff   <= '0;
         member_cnt_ff <= '0;
         removed_ff    <= '0;
         newly_ff      <= '0;
         hb_ff         <= '0;
         group_ff      <= 1'b0;
         status_ff     <= hmt_pkg::ST_DONE;
      end else begin
         fail_to_ff    <= fail_to_in;
         remove_to_ff  <= remove_to_in;
         self_id_ff    <= self_id_in;
         self_port_ff  <= self_port_in;
         t_idx_ff      <= t_idx_in;
         f_idx_ff      <= f_idx_in;
         found_ff      <= found_in;
         free_ff       <= free_in;
         fail_cnt_ff   <= fail_cnt_in;
         member_cnt_ff <= member_cnt_in;
         removed_ff    <= removed_in;
         newly_ff      <= newly_in;
         hb_ff         <= hb_in;
         group_ff      <= group_in;
         status_ff     <= status_in;
      end
   end

   always_comb begin
      sts.req_type   = item_ff.req_type;
      sts.last_entry = item_ff.last_entry;
      sts.self_hit   = item_ff.member_id == self_id_ff;
      sts.t_last     = t_idx_ff == TIW'(TABLE_DEPTH - 1);
      sts.t_d_last   = t_idx_d_ff == TIW'(TABLE_DEPTH - 1);
      sts.f_none     = fail_cnt_ff == '0;
      sts.f_end      = (FCW'(f_idx_d_ff) + FCW'(1)) == fail_cnt_ff;
      sts.f_full     = fail_cnt_ff == FCW'(FAILED_DEPTH);
      sts.f_hit      = fail_rd_ff == key;
      sts.found      = found_ff;
      sts.free_ok    = free_ff;
      sts.hb_newer   = item_ff.member_heartbeat > found_hb_ff;
      sts.e_valid    = tbl_rd_ff.valid;
      sts.e_self     = tbl_rd_ff.valid && tbl_rd_ff.id == self_id_ff
                       && tbl_rd_ff.port == self_port_ff;
      sts.e_erase    = tbl_rd_ff.valid && !age[31] && age > {16'd0, remove_to_ff};
      sts.e_fail     = tbl_rd_ff.valid && !age[31] && age > {16'd0, fail_to_ff};
   end

   assign rsp_data.status             = status_ff;
   assign rsp_data.member_count       = member_cnt_ff;
   assign rsp_data.removed_count      = removed_ff;
   assign rsp_data.newly_failed_count = newly_ff;
   assign rsp_data.own_heartbeat      = hb_ff;
   assign rsp_data.in_group           = group_ff;

endmodule

@@ sv/hmt_controller.sv @@
// ----------------------------------------------------------------------------
// hmt_controller
// Sequencer for the clearing pass, table and failed-store scans, and the
// per-entry sweep of a tick.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hmt_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output logic             rsp_strobe,
   input  hmt_pkg::sts_type sts,
   output hmt_pkg::cmd_type cmd
);

   localparam logic [3:0] S_CLR    = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_DISP   = 4'd2;
   localparam logic [3:0] S_TPRIME = 4'd3;
   localparam logic [3:0] S_TSRCH  = 4'd4;
   localparam logic [3:0] S_RES    = 4'd5;
   localparam logic [3:0] S_FPRIME = 4'd6;
   localparam logic [3:0] S_FSRCH  = 4'd7;
   localparam logic [3:0] S_FADD   = 4'd8;
   localparam logic [3:0] S_TRD    = 4'd9;
   localparam logic [3:0] S_TEV    = 4'd10;
   localparam logic [3:0] S_TNEXT  = 4'd11;
   localparam logic [3:0] S_DONE   = 4'd12;

   logic [3:0] state_ff, state_in;
   logic       is_tick;

   assign is_tick    = sts.req_type == hmt_pkg::REQ_TICK;
   assign busy       = state_ff != S_IDLE;
   assign rsp_strobe = state_ff == S_DONE;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_CLR: begin
            cmd.wipe  = 1'b1;
            cmd.t_inc = 1'b1;
            if (sts.t_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            cmd.f_clr = 1'b1;
            if (is_tick) begin
               state_in = S_TRD;
            end else if (sts.req_type == hmt_pkg::REQ_GOSSIP && !sts.f_none) begin
               state_in = S_FPRIME;
            end else if (sts.req_type == hmt_pkg::REQ_JOIN_REPLY && sts.self_hit) begin
               cmd.st_we   = 1'b1;
               cmd.st_code = hmt_pkg::ST_PRESENT;
               cmd.grp_set = sts.last_entry;
               state_in    = S_DONE;
            end else begin
               state_in = S_TPRIME;
            end
         end
         S_TPRIME: begin
            cmd.t_inc = 1'b1;
            state_in  = S_TSRCH;
         end
         S_TSRCH: begin
            cmd.s_eval = 1'b1;
            cmd.t_inc  = 1'b1;
            if (sts.t_d_last) begin
               state_in = S_RES;
            end
         end
         S_RES: begin
            cmd.st_we = 1'b1;
            if (sts.found) begin
               if (sts.req_type == hmt_pkg::REQ_GOSSIP && sts.hb_newer) begin
                  cmd.upd_gossip = 1'b1;
                  cmd.st_code    = hmt_pkg::ST_DONE;
               end else begin
                  cmd.st_code = hmt_pkg::ST_PRESENT;
               end
            end else if (sts.free_ok) begin
               cmd.ins     = 1'b1;
               cmd.st_code = hmt_pkg::ST_INSERTED;
            end else begin
               cmd.st_code = hmt_pkg::ST_FULL;
            end
            cmd.grp_set = sts.req_type == hmt_pkg::REQ_JOIN_REPLY && sts.last_entry;
            state_in    = S_DONE;
         end
         S_FPRIME: begin
            cmd.f_inc = 1'b1;
            state_in  = S_FSRCH;
         end
         S_FSRCH: begin
            cmd.f_inc = 1'b1;
            if (sts.f_hit) begin
               if (is_tick) begin
                  state_in = S_TNEXT;
               end else begin
                  cmd.st_we   = 1'b1;
                  cmd.st_code = hmt_pkg::ST_FAILED;
                  state_in    = S_DONE;
               end
            end else if (sts.f_end) begin
               state_in = is_tick ? S_FADD : S_TPRIME;
            end
         end
         S_FADD: begin
            if (sts.f_full) begin
               cmd.st_we   = 1'b1;
               cmd.st_code = hmt_pkg::ST_FULL;
            end else begin
               cmd.f_add = 1'b1;
            end
            state_in = S_TNEXT;
         end
         S_TRD: begin
            state_in = S_TEV;
         end
         S_TEV: begin
            cmd.f_clr = 1'b1;
            if (sts.e_valid && !sts.e_self && !sts.e_erase && sts.e_fail) begin
               state_in = sts.f_none ? S_FADD : S_FPRIME;
            end else begin
               cmd.upd_self = sts.e_self;
               cmd.erase    = !sts.e_self && sts.e_erase;
               if (sts.t_last) begin
                  state_in = S_DONE;
               end else begin
                  cmd.t_inc = 1'b1;
                  state_in  = S_TRD;
               end
            end
         end
         S_TNEXT: begin
            if (sts.t_last) begin
               state_in = S_DONE;
            end else begin
               cmd.t_inc = 1'b1;
               state_in  = S_TRD;
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
      end else begin
         state_ff <= state_in;
      end
   end

   `HMT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
   `HMT_ASSERT_NEXT(a_strobe_single, rsp_strobe, !rsp_strobe)
   `HMT_ASSERT_IMPLY(a_insert_free, cmd.ins, sts.free_ok && !sts.found)

endmodule

@@ tb/heartbeat_membership_table_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heartbeat_membership_table_tb
// Self-checking testbench for the gossip membership table.
// A built-in predictor mirrors the member table, the failed store, the own
// heartbeat and the group flag, and works out the result word of every
// accepted request word. A directed opening covers each request kind and
// special case, then random phases under several register settings fill and
// drain the table, and fill the failed store, while the driver idles at random.
// ----------------------------------------------------------------------------
module heartbeat_membership_table_tb;

   localparam int DEPTH = 32;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   hmt_pkg::req_word_type req_data = '0;
   logic                  rsp_strobe;
   hmt_pkg::rsp_word_type rsp_data;
   logic                  csr_we = 1'b0;
   logic [hmt_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]           csr_wdata = '0;

   heartbeat_membership_table dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   // Predictor state.
   logic [15:0]  fail_limit = 16'd5;
   logic [15:0]  remove_limit = 16'd20;
   logic [31:0]  own_id = '0;
   logic [15:0]  own_port = '0;
   logic         member_valid [DEPTH];
   logic [31:0]  member_id [DEPTH];
   logic [15:0]  member_port [DEPTH];
   logic [31:0]  member_hb [DEPTH];
   logic [31:0]  member_stamp [DEPTH];
   logic         dead_valid [DEPTH];
   logic [47:0]  dead_addr [DEPTH];
   logic [31:0]  beat_count = '0;
   logic         joined = 1'b0;

   hmt_pkg::req_word_type pending_words[$];
   hmt_pkg::rsp_word_type expected_words[$];
   int           errors = 0;
   int           gap = 0;
   int           quiet = 0;
   logic         took = 1'b0;
   logic [31:0]  clock_now = 32'd1000;

   initial begin
      for (int i = 0; i < DEPTH; i++) begin
         member_valid[i] = 1'b0;
         dead_valid[i] = 1'b0;
      end
   end

   function automatic int find_member(logic [31:0] id, logic [15:0] port);
      for (int i = 0; i < DEPTH; i++)
         if (member_valid[i] && member_id[i] == id && member_port[i] == port) return i;
      return -1;
   endfunction

   function automatic bit is_dead(logic [47:0] addr);
      for (int i = 0; i < DEPTH; i++)
         if (dead_valid[i] && dead_addr[i] == addr) return 1'b1;
      return 1'b0;
   endfunction

   function automatic logic [2:0] add_member(logic [31:0] id, logic [15:0] port,
                                             logic [31:0] hb, logic [31:0] stamp);
      for (int i = 0; i < DEPTH; i++)
         if (!member_valid[i]) begin
            member_valid[i] = 1'b1;
            member_id[i] = id;
            member_port[i] = port;
            member_hb[i] = hb;
            member_stamp[i] = stamp;
            return hmt_pkg::ST_INSERTED;
         end
      return hmt_pkg::ST_FULL;
   endfunction

   function automatic bit aged(logic [31:0] now, logic [31:0] stamp, logic [15:0] limit);
      logic [31:0] age;
      age = now - stamp;
      if (age[31]) return 1'b0;
      return age > {16'd0, limit};
   endfunction

   function automatic hmt_pkg::rsp_word_type predict_word(hmt_pkg::req_word_type w);
      hmt_pkg::rsp_word_type r;
      int k;
      int removed;
      int fresh_dead;
      int count;
      bit placed;
      logic [47:0] addr;
      r = '0;
      r.status = hmt_pkg::ST_DONE;
      removed = 0;
      fresh_dead = 0;
      count = 0;
      case (w.req_type)
         hmt_pkg::REQ_GOSSIP: begin
            if (is_dead({w.member_id, w.member_port})) r.status = hmt_pkg::ST_FAILED;
            else begin
               k = find_member(w.member_id, w.member_port);
               if (k >= 0) begin
                  if (w.member_heartbeat > member_hb[k]) begin
                     member_hb[k] = w.member_heartbeat;
                     member_stamp[k] = w.current_time;
                     r.status = hmt_pkg::ST_DONE;
                  end else r.status = hmt_pkg::ST_PRESENT;
               end else
                  r.status = add_member(w.member_id, w.member_port,
                                        w.member_heartbeat, w.member_stamp);
            end
         end
         hmt_pkg::REQ_JOIN_REPLY: begin
            if (w.member_id == own_id || find_member(w.member_id, w.member_port) >= 0)
               r.status = hmt_pkg::ST_PRESENT;
            else
               r.status = add_member(w.member_id, w.member_port,
                                     w.member_heartbeat, w.member_stamp);
            if (w.last_entry) joined = 1'b1;
         end
         hmt_pkg::REQ_JOIN_REQ: begin
            if (find_member(w.member_id, w.member_port) >= 0)
               r.status = hmt_pkg::ST_PRESENT;
            else
               r.status = add_member(w.member_id, w.member_port,
                                     w.member_heartbeat, w.current_time);
         end
         default: begin
            beat_count = beat_count + 32'd1;
            k = find_member(own_id, own_port);
            if (k >= 0) begin
               member_hb[k] = beat_count;
               member_stamp[k] = w.current_time;
            end
            for (int i = 0; i < DEPTH; i++) begin
               if (!member_valid[i]) continue;
               if (aged(w.current_time, member_stamp[i], remove_limit)) begin
                  member_valid[i] = 1'b0;
                  removed++;
               end else if (aged(w.current_time, member_stamp[i], fail_limit)) begin
                  addr = {member_id[i], member_port[i]};
                  if (!is_dead(addr)) begin
                     placed = 1'b0;
                     for (int j = 0; j < DEPTH && !placed; j++)
                        if (!dead_valid[j]) begin
                           dead_valid[j] = 1'b1;
                           dead_addr[j] = addr;
                           placed = 1'b1;
                        end
                     if (placed) fresh_dead++;
                     else r.status = hmt_pkg::ST_FULL;
                  end
               end
            end
         end
      endcase
      for (int i = 0; i < DEPTH; i++) if (member_valid[i]) count++;
      r.member_count = count[5:0];
      r.removed_count = removed[5:0];
      r.newly_failed_count = fresh_dead[5:0];
      r.own_heartbeat = beat_count;
      r.in_group = joined;
      return r;
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         errors++;
      end
   endtask

   // Acceptance and result checking.
   always @(posedge clock) begin
      hmt_pkg::rsp_word_type want;
      hmt_pkg::req_word_type sent;
      if (!reset && rsp_strobe) begin
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected result word %h", $time, rsp_data);
            errors++;
         end else begin
            want = expected_words.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_data.status));
            check_field("member_count", 32'(want.member_count),
                        32'(rsp_data.member_count));
            check_field("removed_count", 32'(want.removed_count),
                        32'(rsp_data.removed_count));
            check_field("newly_failed_count", 32'(want.newly_failed_count),
                        32'(rsp_data.newly_failed_count));
            check_field("own_heartbeat", want.own_heartbeat, rsp_data.own_heartbeat);
            check_field("in_group", 32'(want.in_group), 32'(rsp_data.in_group));
         end
      end
      if (!reset && start && !busy && pending_words.size() > 0) begin
         sent = pending_words.pop_front();
         expected_words = {expected_words, predict_word(sent)};
         took <= 1'b1;
      end
   end

   function automatic int next_gap();
      int r;
      if (quiet > 0) begin
         quiet--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 5) quiet = $urandom_range(10, 40);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Request driver.
   always @(negedge clock) begin
      if (!reset) begin
         took <= 1'b0;
         if (start && !took) begin
         end else if (gap > 0) begin
            start <= 1'b0;
            gap <= gap - 1;
         end else if (pending_words.size() > 0) begin
            start <= 1'b1;
            req_data <= pending_words[0];
            gap <= next_gap();
         end else start <= 1'b0;
      end
   end

   task automatic queue_word(logic [1:0] kind, logic [31:0] id, logic [15:0] port,
                             logic [31:0] hb, logic [31:0] stamp, logic [31:0] now,
                             logic last);
      hmt_pkg::req_word_type w;
      w.req_type = kind;
      w.member_id = id;
      w.member_port = port;
      w.member_heartbeat = hb;
      w.member_stamp = stamp;
      w.current_time = now;
      w.last_entry = last;
      pending_words = {pending_words, w};
   endtask

   task automatic drain();
      while (pending_words.size() > 0 || expected_words.size() > 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_reg(logic [hmt_pkg::CSR_IDX_W-1:0] idx, logic [31:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         hmt_pkg::CSR_FAIL_TIMEOUT:   fail_limit = value[15:0];
         hmt_pkg::CSR_REMOVE_TIMEOUT: remove_limit = value[15:0];
         hmt_pkg::CSR_SELF_ID:        own_id = value;
         hmt_pkg::CSR_SELF_PORT:      own_port = value[15:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic set_regs(logic [15:0] fail_t, logic [15:0] remove_t,
                           logic [31:0] id, logic [15:0] port);
      @(negedge clock);
      write_reg(hmt_pkg::CSR_FAIL_TIMEOUT, {16'd0, fail_t});
      write_reg(hmt_pkg::CSR_REMOVE_TIMEOUT, {16'd0, remove_t});
      write_reg(hmt_pkg::CSR_SELF_ID, id);
      write_reg(hmt_pkg::CSR_SELF_PORT, {16'd0, port});
      csr_we <= 1'b0;
   endtask

   task automatic random_words(int n);
      int kind_pick;
      logic [1:0] kind;
      logic [31:0] id;
      logic [15:0] port;
      logic [31:0] hb;
      logic [31:0] stamp;
      logic [31:0] now;
      for (int i = 0; i < n; i++) begin
         kind_pick = $urandom_range(0, 99);
         kind = kind_pick < 40 ? hmt_pkg::REQ_GOSSIP :
                kind_pick < 60 ? hmt_pkg::REQ_JOIN_REPLY :
                kind_pick < 75 ? hmt_pkg::REQ_JOIN_REQ : hmt_pkg::REQ_TICK;
         if (kind == hmt_pkg::REQ_TICK) clock_now = clock_now + $urandom_range(0, 4);
         now = ($urandom_range(0, 29) == 0) ? $urandom : clock_now;
         if ($urandom_range(0, 9) == 0) begin
            id = own_id;
            port = own_port;
         end else if ($urandom_range(0, 14) == 0) begin
            id = $urandom;
            port = 16'($urandom);
         end else begin
            id = $urandom_range(1, 24);
            port = 16'($urandom_range(0, 1));
         end
         hb = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 30);
         stamp = ($urandom_range(0, 14) == 0) ? $urandom : clock_now - $urandom_range(0, 8);
         queue_word(kind, id, port, hb, stamp, now, $urandom_range(0, 7) == 0);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      queue_word(hmt_pkg::REQ_JOIN_REQ, 32'd0, 16'd0, 32'd0, 32'd0, 32'd100, 1'b0);
      queue_word(hmt_pkg::REQ_JOIN_REQ, 32'd0, 16'd0, 32'd4, 32'd0, 32'd100, 1'b0);
      queue_word(hmt_pkg::REQ_JOIN_REQ, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 32'd100, 1'b0);
      queue_word(hmt_pkg::REQ_JOIN_REPLY, 32'd0, 16'd5, 32'd1, 32'd100, 32'd100, 1'b0);
      queue_word(hmt_pkg::REQ_JOIN_REPLY, 32'd9, 16'd2, 32'd1, 32'd100, 32'd100, 1'b0);
      queue_word(hmt_pkg::REQ_JOIN_REPLY, 32'd9, 16'd2, 32'd1, 32'd100, 32'd100, 1'b1);
      queue_word(hmt_pkg::REQ_GOSSIP, 32'd9, 16'd2, 32'd10, 32'd0, 32'd101, 1'b0);
      queue_word(hmt_pkg::REQ_GOSSIP, 32'd9, 16'd2, 32'd3, 32'd0, 32'd101, 1'b0);
      queue_word(hmt_pkg::REQ_GOSSIP, 32'd12, 16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'd101, 1'b0);
      queue_word(hmt_pkg::REQ_TICK, 32'd0, 16'd0, 32'd0, 32'd0, 32'd101, 1'b0);
      queue_word(hmt_pkg::REQ_TICK, 32'd0, 16'd0, 32'd0, 32'd0, 32'd110, 1'b0);
      queue_word(hmt_pkg::REQ_GOSSIP, 32'd9, 16'd2, 32'd50, 32'd0, 32'd110, 1'b0);
      queue_word(hmt_pkg::REQ_TICK, 32'd0, 16'd0, 32'd0, 32'd0, 32'd130, 1'b0);
      queue_word(hmt_pkg::REQ_TICK, 32'd0, 16'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 1'b0);
      queue_word(hmt_pkg::REQ_JOIN_REQ, 32'h0000_0055, 16'hAAAA, 32'hAAAA_AAAA,
                 32'h5555_5555, 32'h5555_5555, 1'b1);
      queue_word(hmt_pkg::REQ_GOSSIP, 32'hAAAA_AAAA, 16'h5555, 32'h5555_5555,
                 32'hAAAA_AAAA, 32'hAAAA_AAAA, 1'b1);
      queue_word(hmt_pkg::REQ_TICK, 32'd0, 16'd0, 32'd0, 32'd0, 32'd0, 1'b1);
      drain();

      set_regs(16'd3, 16'd8, 32'd5, 16'd1);
      random_words(150);
      drain();
      set_regs(16'd0, 16'd0, 32'hFFFF_FFFF, 16'hFFFF);
      random_words(100);
      drain();
      set_regs(16'hFFFF, 16'hFFFF, 32'd7, 16'd0);
      random_words(150);
      drain();
      set_regs(16'd2, 16'd6, 32'd3, 16'd1);
      random_words(200);
      drain();

      if (errors == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #20000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
